### rtl/ims_pkg.sv
// Shared types, codes and the microprogram of the integer merge sorter.
package ims_pkg;

  localparam int ValueW = 31;
  localparam int NumW   = 64;
  localparam int StatW  = 2;
  localparam int StepW  = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SORT = 1'b1;

  localparam logic [StatW-1:0] ST_SORTED = 2'd0;
  localparam logic [StatW-1:0] ST_REJECT = 2'd1;
  localparam logic [StatW-1:0] ST_FULL   = 2'd2;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd3;

  typedef logic [StepW-1:0] step_t;

  localparam step_t U_IDLE      = step_t'(0);
  localparam step_t U_SORT      = step_t'(1);
  localparam step_t U_PASS      = step_t'(2);
  localparam step_t U_RUN       = step_t'(3);
  localparam step_t U_RD_A      = step_t'(4);
  localparam step_t U_CAP_A     = step_t'(5);
  localparam step_t U_CAP_B     = step_t'(6);
  localparam step_t U_MERGE     = step_t'(7);
  localparam step_t U_REFILL    = step_t'(8);
  localparam step_t U_NEXT_RUN  = step_t'(9);
  localparam step_t U_PASS_END  = step_t'(10);
  localparam step_t U_EMIT_INIT = step_t'(11);
  localparam step_t U_EMIT      = step_t'(12);

  typedef enum logic [3:0] {
    ACT_DISPATCH,
    ACT_SORT_INIT,
    ACT_PASS_INIT,
    ACT_RUN_INIT,
    ACT_READ_A,
    ACT_CAP_A,
    ACT_CAP_B,
    ACT_MERGE,
    ACT_REFILL,
    ACT_NEXT_RUN,
    ACT_PASS_END,
    ACT_EMIT_INIT,
    ACT_EMIT
  } act_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START,
    COND_N_ONE,
    COND_LO_END,
    COND_RUN_DONE,
    COND_LAST_PASS,
    COND_EMIT_LAST
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t t_true;
    step_t t_false;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic n_one;
    logic lo_end;
    logic run_done;
    logic last_pass;
    logic emit_last;
    logic hold;
  } flags_t;

  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    unique case (pc)
      U_IDLE:      w = '{ACT_DISPATCH,  COND_START,     U_SORT,      U_IDLE};
      U_SORT:      w = '{ACT_SORT_INIT, COND_N_ONE,     U_EMIT_INIT, U_PASS};
      U_PASS:      w = '{ACT_PASS_INIT, COND_ALWAYS,    U_RUN,       U_RUN};
      U_RUN:       w = '{ACT_RUN_INIT,  COND_LO_END,    U_PASS_END,  U_RD_A};
      U_RD_A:      w = '{ACT_READ_A,    COND_ALWAYS,    U_CAP_A,     U_CAP_A};
      U_CAP_A:     w = '{ACT_CAP_A,     COND_ALWAYS,    U_CAP_B,     U_CAP_B};
      U_CAP_B:     w = '{ACT_CAP_B,     COND_ALWAYS,    U_MERGE,     U_MERGE};
      U_MERGE:     w = '{ACT_MERGE,     COND_RUN_DONE,  U_NEXT_RUN,  U_REFILL};
      U_REFILL:    w = '{ACT_REFILL,    COND_ALWAYS,    U_MERGE,     U_MERGE};
      U_NEXT_RUN:  w = '{ACT_NEXT_RUN,  COND_ALWAYS,    U_RUN,       U_RUN};
      U_PASS_END:  w = '{ACT_PASS_END,  COND_LAST_PASS, U_EMIT_INIT, U_PASS};
      U_EMIT_INIT: w = '{ACT_EMIT_INIT, COND_ALWAYS,    U_EMIT,      U_EMIT};
      U_EMIT:      w = '{ACT_EMIT,      COND_EMIT_LAST, U_IDLE,      U_EMIT};
      default:     w = '{ACT_DISPATCH,  COND_ALWAYS,    U_IDLE,      U_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/ims_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ims_ram #(
  parameter int W     = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/ims_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module ims_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ims_pkg::flags_t flags_i,
  output ims_pkg::act_e   act_o
);

  ims_pkg::step_t  pc_q, pc_d;
  ims_pkg::ucode_t uw;
  logic            cond_ok;

  assign uw    = ims_pkg::ucode_rom(pc_q);
  assign act_o = uw.act;

  always_comb begin
    unique case (uw.cond)
      ims_pkg::COND_ALWAYS:    cond_ok = 1'b1;
      ims_pkg::COND_START:     cond_ok = flags_i.start;
      ims_pkg::COND_N_ONE:     cond_ok = flags_i.n_one;
      ims_pkg::COND_LO_END:    cond_ok = flags_i.lo_end;
      ims_pkg::COND_RUN_DONE:  cond_ok = flags_i.run_done;
      ims_pkg::COND_LAST_PASS: cond_ok = flags_i.last_pass;
      ims_pkg::COND_EMIT_LAST: cond_ok = flags_i.emit_last;
      default:                 cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    if (flags_i.hold) begin
      pc_d = pc_q;
    end else if (cond_ok) begin
      pc_d = uw.t_true;
    end else begin
      pc_d = uw.t_false;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ims_pkg::U_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/ims_dp.sv
// Datapath: ping-pong value banks, merge index registers and the result register.
module ims_dp #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ims_pkg::act_e                 act_i,
  output ims_pkg::flags_t               flags_o,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [ims_pkg::NumW-1:0]      s_tdata_i,
  input  logic                          s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [ims_pkg::ValueW-1:0]    m_value_o,
  output logic [ims_pkg::StatW-1:0]     m_status_o,
  output logic                          m_last_o
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = CW + 2;
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int VW = ims_pkg::ValueW;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          cur_q, cur_d;
  logic [LW-1:0] width_q, width_d, lo_q, lo_d;
  logic [CW-1:0] mid_q, mid_d, hi_q, hi_d, a_q, a_d, b_q, b_d, k_q, k_d;
  logic [VW-1:0] ha_q, ha_d, hb_q, hb_d;
  logic          take_b_q, take_b_d;

  logic                     out_valid_q, out_valid_d;
  logic [VW-1:0]            out_value_q, out_value_d;
  logic [ims_pkg::StatW-1:0] out_status_q, out_status_d;
  logic                     out_last_q, out_last_d;

  logic          we, wbank, re;
  logic [IW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rd_a, rd_b, rdata;

  logic          out_free, s_fire, in_range, full;
  logic          have_a, have_b, take_b;
  logic [LW-1:0] n_l, lo_w, lo_2w, w2, k_inc_l;
  logic [CW-1:0] a_inc, b_inc, k_inc;

  assign rdata    = cur_q ? rd_b : rd_a;
  assign out_free = !out_valid_q || m_tready_i;
  assign s_tready_o = (act_i == ims_pkg::ACT_DISPATCH) && out_free;
  assign s_fire   = s_tvalid_i && s_tready_o;
  assign in_range = (s_tdata_i[ims_pkg::NumW-1:VW] == '0);
  assign full     = (cnt_q == CW'(MAX_ENTRIES));

  assign n_l     = LW'(cnt_q);
  assign w2      = width_q << 1;
  assign lo_w    = lo_q + width_q;
  assign lo_2w   = lo_q + w2;
  assign a_inc   = a_q + CW'(1);
  assign b_inc   = b_q + CW'(1);
  assign k_inc   = k_q + CW'(1);
  assign k_inc_l = LW'(k_q) + LW'(1);
  assign have_a  = a_q < mid_q;
  assign have_b  = b_q < hi_q;
  assign take_b  = have_b && (!have_a || (hb_q < ha_q));

  assign flags_o.start     = s_fire && (s_tuser_i == ims_pkg::OP_SORT) && (cnt_q != '0);
  assign flags_o.n_one     = (cnt_q == CW'(1));
  assign flags_o.lo_end    = (lo_q >= n_l);
  assign flags_o.run_done  = !have_a && !have_b;
  assign flags_o.last_pass = (w2 >= n_l);
  assign flags_o.emit_last = (k_inc_l == n_l);
  assign flags_o.hold      = (act_i == ims_pkg::ACT_EMIT) && !out_free;

  always_comb begin
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    width_d      = width_q;
    lo_d         = lo_q;
    mid_d        = mid_q;
    hi_d         = hi_q;
    a_d          = a_q;
    b_d          = b_q;
    k_d          = k_q;
    ha_d         = ha_q;
    hb_d         = hb_q;
    take_b_d     = take_b_q;
    out_valid_d  = out_valid_q && !m_tready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    we           = 1'b0;
    wbank        = cur_q;
    waddr        = cnt_q[IW-1:0];
    wdata        = s_tdata_i[VW-1:0];
    re           = 1'b0;
    raddr        = a_q[IW-1:0];

    unique case (act_i)
      ims_pkg::ACT_DISPATCH: begin
        if (s_fire) begin
          if (s_tuser_i == ims_pkg::OP_LOAD) begin
            if (!in_range) begin
              out_valid_d  = 1'b1;
              out_value_d  = '0;
              out_status_d = ims_pkg::ST_REJECT;
              out_last_d   = 1'b1;
            end else if (full) begin
              out_valid_d  = 1'b1;
              out_value_d  = '0;
              out_status_d = ims_pkg::ST_FULL;
              out_last_d   = 1'b1;
            end else begin
              we    = 1'b1;
              cnt_d = cnt_q + CW'(1);
            end
          end else if (cnt_q == '0) begin
            out_valid_d  = 1'b1;
            out_value_d  = '0;
            out_status_d = ims_pkg::ST_EMPTY;
            out_last_d   = 1'b1;
          end
        end
      end
      ims_pkg::ACT_SORT_INIT: width_d = LW'(1);
      ims_pkg::ACT_PASS_INIT: lo_d = '0;
      ims_pkg::ACT_RUN_INIT: begin
        a_d   = lo_q[CW-1:0];
        k_d   = lo_q[CW-1:0];
        mid_d = (lo_w >= n_l) ? cnt_q : lo_w[CW-1:0];
        b_d   = (lo_w >= n_l) ? cnt_q : lo_w[CW-1:0];
        hi_d  = (lo_2w >= n_l) ? cnt_q : lo_2w[CW-1:0];
      end
      ims_pkg::ACT_READ_A: begin
        re    = 1'b1;
        raddr = a_q[IW-1:0];
      end
      ims_pkg::ACT_CAP_A: begin
        ha_d  = rdata;
        re    = 1'b1;
        raddr = b_q[IW-1:0];
      end
      ims_pkg::ACT_CAP_B: hb_d = rdata;
      ims_pkg::ACT_MERGE: begin
        if (have_a || have_b) begin
          we       = 1'b1;
          wbank    = !cur_q;
          waddr    = k_q[IW-1:0];
          wdata    = take_b ? hb_q : ha_q;
          k_d      = k_inc;
          take_b_d = take_b;
          re       = 1'b1;
          if (take_b) begin
            b_d   = b_inc;
            raddr = b_inc[IW-1:0];
          end else begin
            a_d   = a_inc;
            raddr = a_inc[IW-1:0];
          end
        end
      end
      ims_pkg::ACT_REFILL: begin
        if (take_b_q) begin
          hb_d = rdata;
        end else begin
          ha_d = rdata;
        end
      end
      ims_pkg::ACT_NEXT_RUN: lo_d = lo_2w;
      ims_pkg::ACT_PASS_END: begin
        cur_d   = !cur_q;
        width_d = w2;
      end
      ims_pkg::ACT_EMIT_INIT: begin
        k_d   = '0;
        re    = 1'b1;
        raddr = '0;
      end
      ims_pkg::ACT_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = rdata;
          out_status_d = ims_pkg::ST_SORTED;
          out_last_d   = flags_o.emit_last;
          k_d          = k_inc;
          re           = 1'b1;
          raddr        = k_inc[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q      <= width_d;
    lo_q         <= lo_d;
    mid_q        <= mid_d;
    hi_q         <= hi_d;
    a_q          <= a_d;
    b_q          <= b_d;
    k_q          <= k_d;
    ha_q         <= ha_d;
    hb_q         <= hb_d;
    take_b_q     <= take_b_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  ims_ram #(.W(VW), .DEPTH(MAX_ENTRIES)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we && !wbank),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  ims_ram #(.W(VW), .DEPTH(MAX_ENTRIES)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we && wbank),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  assign m_tvalid_o = out_valid_q;
  assign m_value_o  = out_value_q;
  assign m_status_o = out_status_q;
  assign m_last_o   = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_cnt_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_i != ims_pkg::ACT_DISPATCH) |=> $stable(cnt_q))
    else $error("entry count moved during sort");

  a_sort_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_i == ims_pkg::ACT_SORT_INIT) |-> (cnt_q != '0))
    else $error("sort started on empty store");

  a_merge_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_i == ims_pkg::ACT_MERGE) && (have_a || have_b) |-> (k_q < hi_q))
    else $error("merge write outside run");

  a_emit_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_i == ims_pkg::ACT_EMIT) && out_free |=> out_valid_q)
    else $error("emit step lost a beat");

endmodule

### rtl/integer_merge_sorter_top.sv
// Integer merge sorter top level: stream ports, microcode sequencer and datapath.
// Load beats (tuser 0): a value in 0..2147483647 is stored, anything else returns one
// reject beat, and a load into a full store returns one store-full beat.
// A sort beat (tuser 1) runs a bottom-up merge sort over the n stored values and then
// streams them in ascending order, tlast on the final one; an empty store returns one
// store-empty beat. Both value banks have a single registered read port, so each run
// first reads the heads of its two halves, and every merged value is followed by a
// refill of that head; merging takes ceil(log2 n) passes, followed by an emit set-up,
// and values are emitted while the receiver keeps up. No input beat is taken until
// the last sorted value is handed over.
module integer_merge_sorter_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] number
  input  logic        s_axis_tuser_i,   // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [30:0] sorted_value, [31] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o
);

  ims_pkg::act_e                 act;
  ims_pkg::flags_t               flags;
  logic [ims_pkg::ValueW-1:0]    value;

  ims_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .act_o   (act)
  );

  ims_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .act_i      (act),
    .flags_o    (flags),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_value_o  (value),
    .m_status_o (m_axis_tuser_o),
    .m_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, value};

endmodule

### tb/tb.sv
// Self-checking stream testbench for the integer merge sorter: random loads and sorts.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES  = 64;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int TAIL_ITEMS   = 30;

  typedef struct {
    logic        op;
    logic [63:0] number;
  } in_beat_t;

  typedef struct {
    logic [ims_pkg::ValueW-1:0] value;
    logic [ims_pkg::StatW-1:0]  status;
    logic                       last;
  } out_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  in_beat_t                   pending_beats[$];
  out_beat_t                  expected_out[$];
  logic [ims_pkg::ValueW-1:0] held_values[$];

  int  fail_count    = 0;
  int  cycle_count   = 0;
  int  sorted_seen   = 0;
  bit  in_beat_taken = 0;
  int  send_gap      = 0;
  bit  send_lively   = 1;
  int  ready_gap     = 0;
  bit  ready_lively  = 1;
  int  hold_cycles   = 0;
  bit  long_hold_done = 0;

  integer_merge_sorter_top #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic out_beat_t status_beat(logic [ims_pkg::StatW-1:0] code);
    out_beat_t ob;
    ob.value  = '0;
    ob.status = code;
    ob.last   = 1'b1;
    return ob;
  endfunction

  // Keep held_values in ascending order so that a sort just reads it out.
  task automatic predict_beat(input logic op, input logic [63:0] number);
    int        idx;
    out_beat_t ob;
    if (op == ims_pkg::OP_LOAD) begin
      if (number[63] || number[62:31] != '0) begin
        expected_out.insert(expected_out.size(), status_beat(ims_pkg::ST_REJECT));
      end else if (held_values.size() >= MAX_ENTRIES) begin
        expected_out.insert(expected_out.size(), status_beat(ims_pkg::ST_FULL));
      end else begin
        idx = 0;
        while (idx < held_values.size() && held_values[idx] <= number[30:0]) idx++;
        held_values.insert(idx, number[30:0]);
      end
    end else if (held_values.size() == 0) begin
      expected_out.insert(expected_out.size(), status_beat(ims_pkg::ST_EMPTY));
    end else begin
      for (idx = 0; idx < held_values.size(); idx++) begin
        ob.value  = held_values[idx];
        ob.status = ims_pkg::ST_SORTED;
        ob.last   = (idx == held_values.size() - 1);
        expected_out.insert(expected_out.size(), ob);
      end
    end
  endtask

  task automatic add_beat(input logic op, input logic [63:0] number);
    in_beat_t b;
    b.op     = op;
    b.number = number;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  function automatic logic [63:0] random_number(bit allow_bad);
    logic [63:0] n;
    int          pick;
    n    = {$urandom(), $urandom()};
    pick = $urandom_range(0, 9);
    if (allow_bad) begin
      if (pick < 5) begin
        n[63] = 1'b1;
      end else if (pick == 5) begin
        n = 64'h0000_0000_8000_0000;
      end else begin
        n[63] = 1'b0;
        if (n[62:31] == '0) n[31] = 1'b1;
      end
    end else begin
      n[63:31] = '0;
      case (pick)
        0: n = '0;
        1: n = 64'h0000_0000_7FFF_FFFF;
        2, 3, 4: n = 64'($urandom_range(0, 15));
        default: ;
      endcase
    end
    return n;
  endfunction

  // Sample both handshakes, predict on input beats and check output beats.
  always @(posedge clk_i) begin
    out_beat_t ob;
    if (rst_ni) begin
      in_beat_taken = s_axis_tvalid_i && s_axis_tready_o;
      if (in_beat_taken) predict_beat(s_axis_tuser_i, s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual data %h status %0d last %0b",
                   $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          fail_count++;
        end else begin
          ob = expected_out.pop_front();
          if (m_axis_tdata_o !== {1'b0, ob.value}) begin
            $display("%0t: value mismatch, expected %h actual %h",
                     $time, {1'b0, ob.value}, m_axis_tdata_o);
            fail_count++;
          end
          if (m_axis_tuser_o !== ob.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, ob.status, m_axis_tuser_o);
            fail_count++;
          end
          if (m_axis_tlast_o !== ob.last) begin
            $display("%0t: last mismatch, expected %0b actual %0b",
                     $time, ob.last, m_axis_tlast_o);
            fail_count++;
          end
          if (ob.status == ims_pkg::ST_SORTED) sorted_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Driver: advance to the next pending beat once the current one is taken.
  always @(negedge clk_i) begin
    in_beat_t b;
    if (rst_ni && (!s_axis_tvalid_i || in_beat_taken)) begin
      in_beat_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_beats.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (send_lively && pending_beats.size() > TAIL_ITEMS &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 12) - 1;
        s_axis_tvalid_i <= 1'b0;
      end else begin
        b = pending_beats.pop_front();
        if ($urandom_range(0, 31) == 0) send_lively = !send_lively;
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= b.number;
        s_axis_tuser_i  <= b.op;
      end
    end
  end

  // Receiver: random back-pressure bursts plus one long hold-off once 40 sorted values are seen.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) ready_lively = !ready_lively;
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else if (!long_hold_done && sorted_seen >= 40) begin
        long_hold_done = 1;
        hold_cycles    = 399;
        m_axis_tready_i <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (ready_lively && pending_beats.size() > TAIL_ITEMS &&
                   $urandom_range(0, 7) == 0) begin
        ready_gap = $urandom_range(1, 12) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    int pick;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = ims_pkg::OP_LOAD;
    m_axis_tready_i = 1'b0;

    add_beat(ims_pkg::OP_SORT, '0);
    add_beat(ims_pkg::OP_LOAD, 64'h0000_0000_0000_0000);
    add_beat(ims_pkg::OP_LOAD, 64'h0000_0000_7FFF_FFFF);
    add_beat(ims_pkg::OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    add_beat(ims_pkg::OP_LOAD, 64'h0000_0000_8000_0000);
    add_beat(ims_pkg::OP_LOAD, 64'h8000_0000_0000_0000);
    add_beat(ims_pkg::OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
    add_beat(ims_pkg::OP_LOAD, 64'h0000_0000_7FFF_FFFF);
    add_beat(ims_pkg::OP_LOAD, 64'h0000_0000_0000_0000);
    add_beat(ims_pkg::OP_LOAD, 64'h0000_0000_0000_0005);
    add_beat(ims_pkg::OP_SORT, 64'h0000_0000_0000_0000);
    add_beat(ims_pkg::OP_SORT, 64'h7FFF_FFFF_FFFF_FFFF);
    add_beat(ims_pkg::OP_LOAD, 64'h0000_0000_0000_0003);
    add_beat(ims_pkg::OP_SORT, 64'hFFFF_FFFF_FFFF_FFFF);

    // Mostly valid loads so the store fills, mixed with invalid loads and sorts; once full, loads overflow.
    for (int i = 0; i < 296; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) add_beat(ims_pkg::OP_SORT, {$urandom(), $urandom()});
      else if (pick < 30) add_beat(ims_pkg::OP_LOAD, random_number(1));
      else add_beat(ims_pkg::OP_LOAD, random_number(0));
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_beats.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_out.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
